// File: design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define AST_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define AST_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

// Next-cycle implication, checked through reset
`define AST_NEXT_ALWAYS(label, clk, a, c) \
  label: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// File: design/tfr_pkg.sv
// Package of types, constants and helpers for the tangent frame unit
`timescale 1ns / 1ps
`default_nettype none
package tfr_pkg;
  localparam int COORD_WIDTH = 32;
  localparam int UNIT_FRACTION_BITS = 14;
  localparam int UNIT_W = UNIT_FRACTION_BITS + 2;
  localparam int USE_W = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
  localparam int VAL_W = 32;
  localparam int DIFF_W = VAL_W + 1;
  localparam int OPND_W = DIFF_W;
  localparam int PROD_W = 2 * OPND_W;
  localparam int ACC_W = PROD_W + 2;
  localparam int S_W = 30;
  localparam int SUM_W = 2 * S_W + 2;
  localparam int ROOT_W = S_W + 1;
  localparam int Q_W = UNIT_FRACTION_BITS + 1;
  localparam int NUM_W = S_W + UNIT_FRACTION_BITS + 1;
  localparam int CNT_W = $clog2(Q_W + 1);
  localparam int IN_TDATA_W = ((5 * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((9 * UNIT_W + 7) / 8) * 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TANGENTS_ENABLE = 1'b0,
    REG_NORMALS_ENABLE  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIFF, ST_TERMS, ST_NORM_T, ST_NORM_B, ST_CROSS, ST_NORM_N, ST_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    NS_IDLE, NS_SHIFT, NS_SQ, NS_SQRT, NS_DIV_LOAD, NS_DIV, NS_DONE
  } norm_state_t;

  typedef struct packed {
    logic en;
    logic clr;
    logic sub;
  } mac_ctl_t;

  typedef struct packed {
    logic start;
    logic sum_valid;
  } norm_ctl_t;

  typedef struct packed {
    logic sq_req;
    logic done;
  } norm_stat_t;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [OPND_W-1:0] opnd_t;
  typedef logic signed [UNIT_W-1:0] unit_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

  function automatic val_t take_coord(input logic [COORD_WIDTH-1:0] raw);
    logic signed [USE_W-1:0] top;
    top = $signed(raw[COORD_WIDTH-1 -: USE_W]);
    return val_t'(top);
  endfunction
endpackage
`default_nettype wire

// File: design/tfr_mac.sv
// Shared signed multiply-accumulate unit with registered product
`timescale 1ns / 1ps
`default_nettype none
module tfr_mac (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire tfr_pkg::mac_ctl_t ctl,
  input  wire tfr_pkg::opnd_t   a,
  input  wire tfr_pkg::opnd_t   b,
  output tfr_pkg::acc_t         acc
);
  logic signed [tfr_pkg::PROD_W-1:0] prod;
  tfr_pkg::mac_ctl_t ctl_d;
  tfr_pkg::acc_t prod_ext;
  tfr_pkg::acc_t base;

  assign prod_ext = tfr_pkg::acc_t'(prod);
  assign base = ctl_d.clr ? '0 : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_d <= '0;
    end else begin
      ctl_d <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (ctl_d.en) begin
      acc <= ctl_d.sub ? (base - prod_ext) : (base + prod_ext);
    end
  end
endmodule
`default_nettype wire

// File: design/tfr_norm.sv
// Vector normalization: shift search, square root and division, one step a cycle except while waiting for the sum
`timescale 1ns / 1ps
`default_nettype none
module tfr_norm (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire tfr_pkg::norm_ctl_t    ctl,
  input  wire tfr_pkg::acc_t         vec [3],
  input  wire logic [tfr_pkg::SUM_W-1:0] sum,
  output tfr_pkg::norm_stat_t        stat,
  output logic [tfr_pkg::S_W-1:0]    sq [3],
  output tfr_pkg::unit_t             res [3]
);
  tfr_pkg::norm_state_t state, state_next;
  logic [tfr_pkg::ACC_W-1:0] mag [3];
  logic [2:0] neg;
  logic [tfr_pkg::SUM_W-1:0] x, root, bitv;
  logic [tfr_pkg::ROOT_W-1:0] rem;
  logic [tfr_pkg::Q_W-1:0] quo, low;
  logic [tfr_pkg::CNT_W-1:0] cnt;
  logic [1:0] idx;

  logic [tfr_pkg::ACC_W-1:0] orv;
  logic [tfr_pkg::SUM_W-1:0] trial;
  logic sq_ge;
  logic [tfr_pkg::ROOT_W-1:0] n;
  logic [tfr_pkg::NUM_W-1:0] num;
  logic [tfr_pkg::ROOT_W:0] dtr;
  logic div_ge;
  logic [tfr_pkg::Q_W-1:0] q_final;

  assign orv = mag[0] | mag[1] | mag[2];
  assign trial = root + bitv;
  assign sq_ge = x >= trial;
  assign n = root[tfr_pkg::ROOT_W-1:0];
  assign num = {1'b0, mag[idx][tfr_pkg::S_W-1:0], {tfr_pkg::UNIT_FRACTION_BITS{1'b0}}}
             + tfr_pkg::NUM_W'(n >> 1);
  assign dtr = {rem, low[tfr_pkg::Q_W-1]};
  assign div_ge = dtr >= {1'b0, n};
  assign q_final = {quo[tfr_pkg::Q_W-2:0], div_ge};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq[i] = mag[i][tfr_pkg::S_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tfr_pkg::NS_IDLE: if (ctl.start) state_next = tfr_pkg::NS_SHIFT;
      tfr_pkg::NS_SHIFT: begin
        if (orv == '0) begin
          state_next = tfr_pkg::NS_DONE;
        end else if (orv[tfr_pkg::ACC_W-1:tfr_pkg::S_W] == '0 && orv[tfr_pkg::S_W-1]) begin
          state_next = tfr_pkg::NS_SQ;
        end
      end
      tfr_pkg::NS_SQ: if (ctl.sum_valid) state_next = tfr_pkg::NS_SQRT;
      tfr_pkg::NS_SQRT: if (bitv == tfr_pkg::SUM_W'(1)) state_next = tfr_pkg::NS_DIV_LOAD;
      tfr_pkg::NS_DIV_LOAD: state_next = tfr_pkg::NS_DIV;
      tfr_pkg::NS_DIV: begin
        if (cnt == tfr_pkg::CNT_W'(1)) begin
          state_next = (idx == 2'd2) ? tfr_pkg::NS_DONE : tfr_pkg::NS_DIV_LOAD;
        end
      end
      tfr_pkg::NS_DONE: state_next = tfr_pkg::NS_IDLE;
      default: state_next = tfr_pkg::NS_IDLE;
    endcase
  end

  always_comb begin
    stat.sq_req = (state == tfr_pkg::NS_SQ);
    stat.done = (state == tfr_pkg::NS_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tfr_pkg::NS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      tfr_pkg::NS_IDLE: begin
        if (ctl.start) begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= vec[i][tfr_pkg::ACC_W-1];
            mag[i] <= vec[i][tfr_pkg::ACC_W-1] ? (-vec[i]) : vec[i];
          end
        end
      end
      tfr_pkg::NS_SHIFT: begin
        if (orv == '0) begin
          for (int i = 0; i < 3; i++) res[i] <= '0;
        end else if (orv[tfr_pkg::ACC_W-1:tfr_pkg::S_W] != '0) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
        end else if (!orv[tfr_pkg::S_W-1]) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
        end
      end
      tfr_pkg::NS_SQ: begin
        x <= sum;
        root <= '0;
        bitv <= tfr_pkg::SUM_W'(1) << (tfr_pkg::SUM_W - 2);
        idx <= 2'd0;
      end
      tfr_pkg::NS_SQRT: begin
        if (sq_ge) begin
          x <= x - trial;
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
      end
      tfr_pkg::NS_DIV_LOAD: begin
        rem <= tfr_pkg::ROOT_W'(num[tfr_pkg::NUM_W-1:tfr_pkg::Q_W]);
        low <= num[tfr_pkg::Q_W-1:0];
        quo <= '0;
        cnt <= tfr_pkg::CNT_W'(tfr_pkg::Q_W);
      end
      tfr_pkg::NS_DIV: begin
        rem <= div_ge ? tfr_pkg::ROOT_W'(dtr - {1'b0, n}) : dtr[tfr_pkg::ROOT_W-1:0];
        quo <= q_final;
        low <= low << 1;
        cnt <= cnt - tfr_pkg::CNT_W'(1);
        if (cnt == tfr_pkg::CNT_W'(1)) begin
          res[idx] <= neg[idx] ? (-tfr_pkg::unit_t'(q_final)) : tfr_pkg::unit_t'(q_final);
          idx <= idx + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

// File: design/triangle_tangent_frame_top.sv
// Top level of the per-face tangent frame unit
// Usage:
//   Vertices enter on the s_ channel: tdata holds pos_x, pos_y, pos_z, tex_u,
//   tex_v; tuser holds first_of_model, which restarts triangle grouping.
//   Every third vertex of a model closes a face; while tangents are enabled,
//   one result per face leaves on the m_ channel with the unit tangent,
//   bitangent and normal in Q1.14, and tuser set when the UV area is zero.
//   The first two vertices of a face are only stored. For the closing
//   vertex, one shared 33x33 multiply-accumulate unit forms the area and
//   edge products, and the normalizer makes up to three passes (one-bit
//   shift search, 31-step square root, three 15-step divisions).
//   s_tready is low while the closing vertex is processed.
//   The result sits in an output register; the next face may be computed
//   while it waits, and the unit holds before loading it while the receiver
//   stalls. Configuration writes go through cfg_write at any idle time.
//   Reset clears the vertex phase, the output valid and both enables to one.
`timescale 1ns / 1ps
`default_nettype none
module triangle_tangent_frame_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [tfr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tfr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v
  input  wire logic [tfr_pkg::IN_TDATA_W-1:0]     s_tdata,
  // first_of_model
  input  wire logic                               s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // tangent_x/y/z, bitangent_x/y/z, normal_x/y/z
  output logic [tfr_pkg::OUT_TDATA_W-1:0]         m_tdata,
  // degenerate
  output logic                                    m_tuser
);
  localparam int CW = tfr_pkg::COORD_WIDTH;

  tfr_pkg::top_state_t state, state_next;
  logic [3:0] step, step_next;
  logic [1:0] phase, ph_eff;
  logic tangents_enable, normals_enable;
  logic accept, out_load;

  tfr_pkg::val_t p0 [3], p1 [3], p2 [3];
  tfr_pkg::val_t uv0 [2], uv1 [2], uv2 [2];
  tfr_pkg::val_t cur_p [3], cur_uv [2];
  tfr_pkg::diff_t eb [3], ec [3], bu, bv, cu, cv;
  tfr_pkg::acc_t area, tw [3], bw [3], cw [3], nvec [3];
  tfr_pkg::unit_t tv [3], bvec [3], nv [3];
  logic degen;

  tfr_pkg::mac_ctl_t mac_ctl;
  tfr_pkg::opnd_t op_a, op_b;
  tfr_pkg::acc_t acc;
  tfr_pkg::norm_ctl_t norm_ctl;
  tfr_pkg::norm_stat_t norm_stat;
  logic [tfr_pkg::S_W-1:0] sq [3];
  tfr_pkg::unit_t nres [3];
  logic [2:0] term, cap;
  logic [1:0] sq_idx;

  tfr_mac u_mac (.clk(clk), .rst(rst), .ctl(mac_ctl), .a(op_a), .b(op_b), .acc(acc));

  tfr_norm u_norm (
    .clk(clk), .rst(rst), .ctl(norm_ctl), .vec(nvec),
    .sum(acc[tfr_pkg::SUM_W-1:0]), .stat(norm_stat), .sq(sq), .res(nres)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cur_p[i] = tfr_pkg::take_coord(s_tdata[i*CW +: CW]);
    end
    cur_uv[0] = tfr_pkg::take_coord(s_tdata[3*CW +: CW]);
    cur_uv[1] = tfr_pkg::take_coord(s_tdata[4*CW +: CW]);
  end

  assign accept = s_tvalid && s_tready;
  assign ph_eff = s_tuser ? 2'd0 : phase;
  assign out_load = !m_tvalid || m_tready;
  assign term = step[3:1];
  assign cap = 3'(step - 4'd3 >> 1);
  assign sq_idx = 2'(step - 4'd1);

  // next state
  always_comb begin
    state_next = state;
    step_next = step;
    case (state)
      tfr_pkg::ST_IDLE: begin
        if (accept && ph_eff == 2'd2 && tangents_enable) begin
          state_next = tfr_pkg::ST_DIFF;
        end
      end
      tfr_pkg::ST_DIFF: begin
        state_next = tfr_pkg::ST_TERMS;
        step_next = '0;
      end
      tfr_pkg::ST_TERMS: begin
        step_next = step + 4'd1;
        if (step == 4'd15) begin
          step_next = '0;
          state_next = (area == '0) ? tfr_pkg::ST_OUT : tfr_pkg::ST_NORM_T;
        end
      end
      tfr_pkg::ST_CROSS: begin
        step_next = step + 4'd1;
        if (step == 4'd7) begin
          step_next = '0;
          state_next = tfr_pkg::ST_NORM_N;
        end
      end
      tfr_pkg::ST_NORM_T, tfr_pkg::ST_NORM_B, tfr_pkg::ST_NORM_N: begin
        if (step == 4'd0) begin
          step_next = 4'd1;
        end else if (step < 4'd6 && norm_stat.sq_req) begin
          step_next = step + 4'd1;
        end
        if (norm_stat.done) begin
          step_next = '0;
          case (state)
            tfr_pkg::ST_NORM_T: state_next = tfr_pkg::ST_NORM_B;
            tfr_pkg::ST_NORM_B: state_next = normals_enable ? tfr_pkg::ST_CROSS
                                                            : tfr_pkg::ST_OUT;
            default: state_next = tfr_pkg::ST_OUT;
          endcase
        end
      end
      tfr_pkg::ST_OUT: if (out_load) state_next = tfr_pkg::ST_IDLE;
      default: state_next = tfr_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready = (state == tfr_pkg::ST_IDLE);
    mac_ctl = '0;
    op_a = '0;
    op_b = '0;
    norm_ctl = '0;
    nvec = tw;
    case (state)
      tfr_pkg::ST_TERMS: begin
        mac_ctl.en = (step < 4'd14);
        mac_ctl.clr = !step[0];
        mac_ctl.sub = step[0];
        case (term)
          3'd0: begin op_a = step[0] ? cu : bu; op_b = step[0] ? bv : cv; end
          3'd1: begin op_a = step[0] ? ec[0] : eb[0]; op_b = step[0] ? bv : cv; end
          3'd2: begin op_a = step[0] ? ec[1] : eb[1]; op_b = step[0] ? bv : cv; end
          3'd3: begin op_a = step[0] ? ec[2] : eb[2]; op_b = step[0] ? bv : cv; end
          3'd4: begin op_a = step[0] ? cu : bu; op_b = step[0] ? eb[0] : ec[0]; end
          3'd5: begin op_a = step[0] ? cu : bu; op_b = step[0] ? eb[1] : ec[1]; end
          3'd6: begin op_a = step[0] ? cu : bu; op_b = step[0] ? eb[2] : ec[2]; end
          default: begin op_a = '0; op_b = '0; end
        endcase
      end
      tfr_pkg::ST_CROSS: begin
        mac_ctl.en = (step < 4'd6);
        mac_ctl.clr = !step[0];
        mac_ctl.sub = step[0];
        case (term)
          3'd0: begin
            op_a = tfr_pkg::opnd_t'(step[0] ? tv[2] : tv[1]);
            op_b = tfr_pkg::opnd_t'(step[0] ? bvec[1] : bvec[2]);
          end
          3'd1: begin
            op_a = tfr_pkg::opnd_t'(step[0] ? tv[0] : tv[2]);
            op_b = tfr_pkg::opnd_t'(step[0] ? bvec[2] : bvec[0]);
          end
          3'd2: begin
            op_a = tfr_pkg::opnd_t'(step[0] ? tv[1] : tv[0]);
            op_b = tfr_pkg::opnd_t'(step[0] ? bvec[0] : bvec[1]);
          end
          default: begin op_a = '0; op_b = '0; end
        endcase
      end
      tfr_pkg::ST_NORM_T, tfr_pkg::ST_NORM_B, tfr_pkg::ST_NORM_N: begin
        case (state)
          tfr_pkg::ST_NORM_B: nvec = bw;
          tfr_pkg::ST_NORM_N: nvec = cw;
          default: nvec = tw;
        endcase
        norm_ctl.start = (step == 4'd0);
        norm_ctl.sum_valid = (step == 4'd5) && norm_stat.sq_req;
        if (norm_stat.sq_req && step >= 4'd1 && step <= 4'd3) begin
          mac_ctl.en = 1'b1;
          mac_ctl.clr = (step == 4'd1);
          op_a = tfr_pkg::opnd_t'({1'b0, sq[sq_idx]});
          op_b = tfr_pkg::opnd_t'({1'b0, sq[sq_idx]});
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tfr_pkg::ST_IDLE;
      step <= '0;
      phase <= '0;
      tangents_enable <= 1'b1;
      normals_enable <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      step <= step_next;
      if (accept) begin
        phase <= (ph_eff == 2'd2) ? 2'd0 : ph_eff + 2'd1;
      end
      if (cfg_write) begin
        case (tfr_pkg::cfg_reg_t'(cfg_index))
          tfr_pkg::REG_TANGENTS_ENABLE: tangents_enable <= cfg_data[0];
          tfr_pkg::REG_NORMALS_ENABLE: normals_enable <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (state == tfr_pkg::ST_OUT && out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      case (ph_eff)
        2'd0: begin p0 <= cur_p; uv0 <= cur_uv; end
        2'd1: begin p1 <= cur_p; uv1 <= cur_uv; end
        default: begin p2 <= cur_p; uv2 <= cur_uv; end
      endcase
    end
    case (state)
      tfr_pkg::ST_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          eb[i] <= tfr_pkg::diff_t'(p1[i]) - tfr_pkg::diff_t'(p0[i]);
          ec[i] <= tfr_pkg::diff_t'(p2[i]) - tfr_pkg::diff_t'(p0[i]);
          tv[i] <= '0;
          bvec[i] <= '0;
          nv[i] <= '0;
        end
        bu <= tfr_pkg::diff_t'(uv1[0]) - tfr_pkg::diff_t'(uv0[0]);
        bv <= tfr_pkg::diff_t'(uv1[1]) - tfr_pkg::diff_t'(uv0[1]);
        cu <= tfr_pkg::diff_t'(uv2[0]) - tfr_pkg::diff_t'(uv0[0]);
        cv <= tfr_pkg::diff_t'(uv2[1]) - tfr_pkg::diff_t'(uv0[1]);
        degen <= 1'b0;
      end
      tfr_pkg::ST_TERMS: begin
        if (step[0] && step >= 4'd3) begin
          case (cap)
            3'd0: area <= acc;
            3'd1: tw[0] <= area[tfr_pkg::ACC_W-1] ? -acc : acc;
            3'd2: tw[1] <= area[tfr_pkg::ACC_W-1] ? -acc : acc;
            3'd3: tw[2] <= area[tfr_pkg::ACC_W-1] ? -acc : acc;
            3'd4: bw[0] <= area[tfr_pkg::ACC_W-1] ? -acc : acc;
            3'd5: bw[1] <= area[tfr_pkg::ACC_W-1] ? -acc : acc;
            default: bw[2] <= area[tfr_pkg::ACC_W-1] ? -acc : acc;
          endcase
        end
        if (step == 4'd15 && area == '0) begin
          degen <= 1'b1;
        end
      end
      tfr_pkg::ST_CROSS: begin
        if (step[0] && step >= 4'd3) begin
          case (cap)
            3'd0: cw[0] <= acc;
            3'd1: cw[1] <= acc;
            default: cw[2] <= acc;
          endcase
        end
      end
      tfr_pkg::ST_NORM_T: if (norm_stat.done) tv <= nres;
      tfr_pkg::ST_NORM_B: if (norm_stat.done) bvec <= nres;
      tfr_pkg::ST_NORM_N: if (norm_stat.done) nv <= nres;
      tfr_pkg::ST_OUT: begin
        if (out_load) begin
          m_tdata <= tfr_pkg::OUT_TDATA_W'({nv[2], nv[1], nv[0],
                                            bvec[2], bvec[1], bvec[0],
                                            tv[2], tv[1], tv[0]});
          m_tuser <= degen;
        end
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

// File: design/tfr_checker.sv
// Port-level checker for the tangent frame unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tfr_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [tfr_pkg::OUT_TDATA_W-1:0] m_tdata,
  input wire logic                            m_tuser
);
  logic signed [tfr_pkg::UNIT_W-1:0] tan_x;
  logic signed [tfr_pkg::UNIT_W-1:0] unit_one;

  assign tan_x = m_tdata[tfr_pkg::UNIT_W-1:0];
  assign unit_one = tfr_pkg::UNIT_W'(1) << tfr_pkg::UNIT_FRACTION_BITS;

  `AST_NEXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `AST_IMPLY(a_degen_zero, clk, rst, m_tvalid && m_tuser, m_tdata == '0)
  `AST_IMPLY(a_unit_range, clk, rst, m_tvalid, (tan_x <= unit_one) && (tan_x >= -unit_one))
  `AST_NEXT_ALWAYS(a_reset_idle, clk, rst, !m_tvalid)
endmodule

bind triangle_tangent_frame_top tfr_checker u_tfr_checker (.*);
`default_nettype wire

// File: tb/tb.sv
// Testbench for the per-face tangent frame unit: directed table plus random faces
`timescale 1ns / 1ps
module tb;
  typedef struct packed {
    logic [tfr_pkg::UNIT_W-1:0] nz, ny, nx, bz, by, bx, tz, ty, tx;
  } frame_t;

  typedef struct {
    frame_t vec;
    logic   degen;
  } face_t;

  typedef struct {
    logic              first;
    logic signed [31:0] px, py, pz, u, v;
    logic              chk;
    face_t             want;
  } vtx_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [tfr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tfr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [tfr_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [tfr_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic m_tuser;

  triangle_tangent_frame_top dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic tan_en, nrm_en;
  int phase;
  logic signed [63:0] hp [6];
  logic signed [63:0] ht [4];
  face_t faces_due [$];
  logic  check_due [$];
  face_t pinned_due [$];
  int errors = 0;
  int stall_cnt = 0;
  bit rx_stall_long = 0;

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void unit_vec(input logic signed [127:0] c [3],
                                   output logic signed [63:0] o [3]);
    logic [127:0] m [3];
    logic [63:0] s [3];
    logic [63:0] sum, n, q;
    int len, l;
    len = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i] < 0 ? -c[i] : c[i];
      l = 0;
      for (int k = 0; k < 128; k++) if (m[i][k]) l = k + 1;
      if (l > len) len = l;
    end
    if (len == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return;
    end
    for (int i = 0; i < 3; i++) begin
      if (len > 30) s[i] = 64'(m[i] >> (len - 30));
      else s[i] = 64'(m[i] << (30 - len));
      sum += s[i] * s[i];
    end
    n = isqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((s[i] << tfr_pkg::UNIT_FRACTION_BITS) + n / 2) / n;
      o[i] = c[i] < 0 ? -$signed(q) : $signed(q);
    end
  endfunction

  // returns 1 when the vertex closes a face that yields a result
  function automatic bit frame_of_vertex(input logic first,
      input logic signed [31:0] px, py, pz, u, v, output face_t f);
    logic signed [63:0] p [3];
    logic signed [63:0] eb [3], ec [3], t [3], b [3], nn [3];
    logic signed [63:0] bu, bv, cu, cv;
    logic signed [127:0] area;
    logic signed [127:0] tw [3], bw [3], cw [3];
    p[0] = px; p[1] = py; p[2] = pz;
    f = '{vec: '0, degen: 1'b0};
    if (first) phase = 0;
    if (phase < 2) begin
      for (int i = 0; i < 3; i++) hp[phase*3+i] = p[i];
      ht[phase*2] = u;
      ht[phase*2+1] = v;
      phase++;
      return 0;
    end
    phase = 0;
    if (!tan_en) return 0;
    for (int i = 0; i < 3; i++) begin
      eb[i] = hp[3+i] - hp[i];
      ec[i] = p[i] - hp[i];
    end
    bu = ht[2] - ht[0]; bv = ht[3] - ht[1];
    cu = 64'(u) - ht[0]; cv = 64'(v) - ht[1];
    area = 128'(bu) * 128'(cv) - 128'(cu) * 128'(bv);
    if (area == 0) begin
      f.degen = 1'b1;
      return 1;
    end
    for (int i = 0; i < 3; i++) begin
      tw[i] = 128'(eb[i]) * 128'(cv) - 128'(ec[i]) * 128'(bv);
      bw[i] = 128'(bu) * 128'(ec[i]) - 128'(cu) * 128'(eb[i]);
      if (area < 0) begin
        tw[i] = -tw[i];
        bw[i] = -bw[i];
      end
    end
    unit_vec(tw, t);
    unit_vec(bw, b);
    for (int i = 0; i < 3; i++) nn[i] = 0;
    if (nrm_en) begin
      cw[0] = 128'(t[1]) * 128'(b[2]) - 128'(t[2]) * 128'(b[1]);
      cw[1] = 128'(t[2]) * 128'(b[0]) - 128'(t[0]) * 128'(b[2]);
      cw[2] = 128'(t[0]) * 128'(b[1]) - 128'(t[1]) * 128'(b[0]);
      unit_vec(cw, nn);
    end
    f.vec = {nn[2][tfr_pkg::UNIT_W-1:0], nn[1][tfr_pkg::UNIT_W-1:0],
             nn[0][tfr_pkg::UNIT_W-1:0],
             b[2][tfr_pkg::UNIT_W-1:0], b[1][tfr_pkg::UNIT_W-1:0],
             b[0][tfr_pkg::UNIT_W-1:0],
             t[2][tfr_pkg::UNIT_W-1:0], t[1][tfr_pkg::UNIT_W-1:0],
             t[0][tfr_pkg::UNIT_W-1:0]};
    return 1;
  endfunction

  task automatic write_reg(input tfr_pkg::cfg_reg_t idx, input logic val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == tfr_pkg::REG_TANGENTS_ENABLE) tan_en = val;
    else nrm_en = val;
  endtask

  task automatic send_vertex(input logic first, input logic signed [31:0] px, py, pz,
                             u, v, input logic pinned, input face_t pin);
    face_t f;
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= first;
    s_tdata <= tfr_pkg::IN_TDATA_W'({v, u, pz, py, px});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (frame_of_vertex(first, px, py, pz, u, v, f)) begin
      faces_due = {faces_due, f};
      check_due = {check_due, pinned};
      pinned_due = {pinned_due, pin};
    end
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (faces_due.size() != 0) @(negedge clk);
    repeat (500) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rnd_coord(int mode);
    case (mode)
      0: return $signed($urandom());
      1: return $signed($urandom_range(0, 2000)) - 1000;
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 65536 * 8)) - 65536 * 4;
    endcase
  endfunction

  // result check
  always @(posedge clk) begin
    face_t w, p;
    logic pin;
    frame_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[9*tfr_pkg::UNIT_W-1:0];
      if (faces_due.size() == 0) begin
        $display("%0t unexpected face: got %h/%b", $time, got, m_tuser);
        errors++;
      end else begin
        w = faces_due.pop_front();
        pin = check_due.pop_front();
        p = pinned_due.pop_front();
        if (pin && (p.vec !== w.vec || p.degen !== w.degen)) begin
          $display("%0t table mismatch: table %h/%b predicted %h/%b",
                   $time, p.vec, p.degen, w.vec, w.degen);
          errors++;
        end
        if (got !== w.vec || m_tuser !== w.degen) begin
          $display("%0t face mismatch: expected %h/%b actual %h/%b",
                   $time, w.vec, w.degen, got, m_tuser);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if ($urandom_range(0, 49) == 0) rx_stall_long = !rx_stall_long;
    if (rx_stall_long) m_tready <= ($urandom_range(0, 15) == 0);
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) stall_cnt = 0;
    else stall_cnt++;
    if (stall_cnt > 20000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  vtx_row_t dir_rows [$];

  function automatic vtx_row_t row(logic first, int px, py, pz, u, v,
                                   logic chk = 0, face_t want = '{default: '0});
    vtx_row_t r;
    r = '{first, px, py, pz, u, v, chk, want};
    return r;
  endfunction

  initial begin
    face_t zero_degen, none;
    int mode;
    logic signed [31:0] c [15];
    zero_degen = '{vec: '0, degen: 1'b1};
    none = '{vec: '0, degen: 1'b0};
    tan_en = 1; nrm_en = 1; phase = 0;
    for (int i = 0; i < 6; i++) hp[i] = 0;
    for (int i = 0; i < 4; i++) ht[i] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // unit right triangle, zero area, collinear UV, extremes, a leftover vertex
    dir_rows = {dir_rows, row(1, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, row(0, 65536, 0, 0, 65536, 0)};
    dir_rows = {dir_rows, row(0, 0, 65536, 0, 0, 65536)};
    dir_rows = {dir_rows, row(1, 5, 6, 7, 9, 9)};
    dir_rows = {dir_rows, row(0, 1, 2, 3, 9, 9)};
    dir_rows = {dir_rows, row(0, 8, 8, 8, 9, 9, 1, zero_degen)};
    dir_rows = {dir_rows, row(0, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, row(0, 0, 0, 0, 100, 200)};
    dir_rows = {dir_rows, row(0, 0, 0, 0, 300, 600, 1, zero_degen)};
    dir_rows = {dir_rows, row(1, 32'h80000000, 32'h80000000, 32'h80000000,
                              32'h80000000, 32'h80000000)};
    dir_rows = {dir_rows, row(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                              32'h7fffffff, 32'h80000000)};
    dir_rows = {dir_rows, row(0, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                              32'h80000000, 32'h7fffffff)};
    dir_rows = {dir_rows, row(0, 1, 1, 1, 1, 1)};
    dir_rows = {dir_rows, row(1, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, row(0, 0, 0, 0, 1, 0)};
    dir_rows = {dir_rows, row(0, 0, 0, 0, 0, 1)};
    dir_rows = {dir_rows, row(1, 3, 4, 5, 6, 7)};
    dir_rows = {dir_rows, row(0, -3, 40, 50, -6, 70)};
    dir_rows = {dir_rows, row(0, 30, -4, 5, 60, 7)};
    for (int i = 0; i < dir_rows.size(); i++)
      send_vertex(dir_rows[i].first, dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz,
                  dir_rows[i].u, dir_rows[i].v, dir_rows[i].chk, dir_rows[i].want);
    drain();

    // five register phases, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(tfr_pkg::REG_NORMALS_ENABLE, 0);
          write_reg(tfr_pkg::REG_TANGENTS_ENABLE, 1);
        end
        1: write_reg(tfr_pkg::REG_TANGENTS_ENABLE, 0);
        2: begin
          write_reg(tfr_pkg::REG_TANGENTS_ENABLE, 1);
          write_reg(tfr_pkg::REG_NORMALS_ENABLE, 1);
        end
        3: write_reg(tfr_pkg::REG_NORMALS_ENABLE, 0);
        default: write_reg(tfr_pkg::REG_NORMALS_ENABLE, 1);
      endcase
      for (int t = 0; t < (ph == 1 ? 50 : 128); t++) begin
        mode = $urandom_range(0, 3);
        for (int k = 0; k < 15; k++) c[k] = rnd_coord(mode);
        if ($urandom_range(0, 9) == 0) c[14] = c[9] + (c[9] - c[4]);
        if ($urandom_range(0, 9) == 0) begin
          c[13] = c[3]; c[14] = c[4];
        end
        for (int k = 0; k < 3; k++)
          send_vertex(k == 0 ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 30) == 0),
                      c[k*5], c[k*5+1], c[k*5+2], c[k*5+3], c[k*5+4], 0, none);
        if ($urandom_range(0, 12) == 0)
          send_vertex(0, rnd_coord(0), rnd_coord(0), rnd_coord(0), rnd_coord(0),
                      rnd_coord(0), 0, none);
      end
      drain();
    end

    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule
